// ===== rtl/cwr_pkg.sv =====
package cwr_pkg;

  // fixed port widths
  localparam int FIELD_W   = 32;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_SPAN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CONFIG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REF_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd3;

  // control travelling alongside each transaction
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
  } cwr_ctrl_t;

endpackage

// ===== rtl/cwr_front.sv =====
module cwr_front #(
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [POSITION_BITS-1:0] occ_start,
  input  logic [POSITION_BITS-1:0] occ_span,
  input  logic [POSITION_BITS-1:0] ref_len,
  input  logic [POSITION_BITS-1:0] win_len,
  input  logic [POSITION_BITS-1:0] stride,
  input  logic [POSITION_BITS-1:0] count,
  output cwr_pkg::cwr_ctrl_t       ctrl_o,
  output logic [POSITION_BITS-1:0] min_start_o,
  output logic [POSITION_BITS-1:0] max_start_o
);
  import cwr_pkg::*;

  localparam int P = POSITION_BITS;

  cwr_ctrl_t        a_ctrl_r, a_ctrl_nxt;
  logic [P-1:0]     a_start_r;
  logic [P-1:0]     a_min_r, a_min_nxt;
  logic [2*P-1:0]   a_prod_r, a_prod_nxt;
  logic [P:0]       occ_end;
  logic [P:0]       min_wide;

  cwr_ctrl_t        b_ctrl_r, b_ctrl_nxt;
  logic [P-1:0]     b_min_r;
  logic [P-1:0]     b_max_r, b_max_nxt;

  // stage A: error checks in priority order, earliest window start, last window start
  always_comb begin
    occ_end  = {1'b0, occ_start} + {1'b0, occ_span};
    min_wide = (occ_end > {1'b0, win_len}) ? occ_end - {1'b0, win_len} : '0;
    a_min_nxt = min_wide[P-1:0];
    a_prod_nxt = {{P{1'b0}}, count - P'(1)} * {{P{1'b0}}, stride};
    a_ctrl_nxt.valid = in_valid;
    if (occ_span == '0) begin
      a_ctrl_nxt.status = ST_ZERO_SPAN;
    end else if (win_len == '0 || stride == '0 || count == '0 || ref_len == '0) begin
      a_ctrl_nxt.status = ST_BAD_CONFIG;
    end else if (occ_span > win_len) begin
      a_ctrl_nxt.status = ST_TOO_LONG;
    end else if (occ_start >= ref_len || occ_end > {1'b0, ref_len}) begin
      a_ctrl_nxt.status = ST_NONE;
    end else begin
      a_ctrl_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctrl_r <= '0;
    end else begin
      a_ctrl_r <= a_ctrl_nxt;
    end
    a_start_r <= occ_start;
    a_min_r   <= a_min_nxt;
    a_prod_r  <= a_prod_nxt;
  end

  // stage B: clamp the start to the last window start, check for an empty span
  always_comb begin
    b_max_nxt  = ({{P{1'b0}}, a_start_r} < a_prod_r) ? a_start_r : a_prod_r[P-1:0];
    b_ctrl_nxt = a_ctrl_r;
    if (a_ctrl_r.status == ST_OK && a_min_r > b_max_nxt) begin
      b_ctrl_nxt.status = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctrl_r <= '0;
    end else begin
      b_ctrl_r <= b_ctrl_nxt;
    end
    b_min_r <= a_min_r;
    b_max_r <= b_max_nxt;
  end

  assign ctrl_o      = b_ctrl_r;
  assign min_start_o = b_min_r;
  assign max_start_o = b_max_r;

endmodule

// ===== rtl/cwr_div_cell.sv =====
module cwr_div_cell #(
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [POSITION_BITS-1:0] stride,
  input  cwr_pkg::cwr_ctrl_t       ctrl_i,
  input  logic [POSITION_BITS-1:0] rem_lo_i,
  input  logic [POSITION_BITS-1:0] dvd_lo_i,
  input  logic [POSITION_BITS-1:0] rem_hi_i,
  input  logic [POSITION_BITS-1:0] dvd_hi_i,
  output cwr_pkg::cwr_ctrl_t       ctrl_o,
  output logic [POSITION_BITS-1:0] rem_lo_o,
  output logic [POSITION_BITS-1:0] dvd_lo_o,
  output logic [POSITION_BITS-1:0] rem_hi_o,
  output logic [POSITION_BITS-1:0] dvd_hi_o
);
  import cwr_pkg::*;

  localparam int P = POSITION_BITS;

  cwr_ctrl_t    ctrl_r;
  logic [P-1:0] rem_lo_r, rem_lo_nxt, dvd_lo_r, dvd_lo_nxt;
  logic [P-1:0] rem_hi_r, rem_hi_nxt, dvd_hi_r, dvd_hi_nxt;
  logic [P:0]   sh_lo, sh_hi, diff_lo, diff_hi;
  logic         q_lo, q_hi;

  // one restoring step per lane: shift in the next dividend bit, trial subtract
  always_comb begin
    sh_lo   = {rem_lo_i, dvd_lo_i[P-1]};
    sh_hi   = {rem_hi_i, dvd_hi_i[P-1]};
    diff_lo = sh_lo - {1'b0, stride};
    diff_hi = sh_hi - {1'b0, stride};
    q_lo    = (sh_lo >= {1'b0, stride});
    q_hi    = (sh_hi >= {1'b0, stride});
    rem_lo_nxt = q_lo ? diff_lo[P-1:0] : sh_lo[P-1:0];
    rem_hi_nxt = q_hi ? diff_hi[P-1:0] : sh_hi[P-1:0];
    dvd_lo_nxt = {dvd_lo_i[P-2:0], q_lo};
    dvd_hi_nxt = {dvd_hi_i[P-2:0], q_hi};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
    rem_lo_r <= rem_lo_nxt;
    dvd_lo_r <= dvd_lo_nxt;
    rem_hi_r <= rem_hi_nxt;
    dvd_hi_r <= dvd_hi_nxt;
  end

  assign ctrl_o   = ctrl_r;
  assign rem_lo_o = rem_lo_r;
  assign dvd_lo_o = dvd_lo_r;
  assign rem_hi_o = rem_hi_r;
  assign dvd_hi_o = dvd_hi_r;

endmodule

// ===== rtl/covering_window_range_top.sv =====
// Channel     | Ports                                              | Direction
// ------------+----------------------------------------------------+----------
// input       | start, busy, in_occurrence_start, in_occurrence_span | in, busy out
// result      | out_valid, out_status, out_first_window, out_last_window | out
// config      | cfg_we, cfg_index, cfg_data                        | in
//
// One transaction is taken every cycle; busy is always low.
// Each result passes through two check stages, one divider cell per position bit,
// then the output register.
// Results come out in order, each with out_valid high for a single cycle.
// Synchronous reset clears the configuration registers and all valid flags.
// The receiver cannot stall, so nothing is ever held back.
module covering_window_range_top #(
  parameter int POSITION_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [cwr_pkg::FIELD_W-1:0]      in_occurrence_start,
  input  logic [cwr_pkg::FIELD_W-1:0]      in_occurrence_span,
  output logic                             out_valid,
  output logic [cwr_pkg::STATUS_W-1:0]     out_status,
  output logic [cwr_pkg::FIELD_W-1:0]      out_first_window,
  output logic [cwr_pkg::FIELD_W-1:0]      out_last_window,
  input  logic                             cfg_we,
  input  logic [cwr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cwr_pkg::FIELD_W-1:0]      cfg_data
);
  import cwr_pkg::*;

  localparam int P = POSITION_BITS;

  logic [P-1:0] ref_len_r, win_len_r, stride_r, count_r;

  cwr_ctrl_t    ctrl_c   [0:P];
  logic [P-1:0] rem_lo_c [0:P];
  logic [P-1:0] dvd_lo_c [0:P];
  logic [P-1:0] rem_hi_c [0:P];
  logic [P-1:0] dvd_hi_c [0:P];

  logic [P-1:0]          lo;
  cwr_ctrl_t             fin_ctrl;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [FIELD_W-1:0]    out_first_r, out_last_r;

  // configuration registers, kept at position width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r <= '0;
      win_len_r <= '0;
      stride_r  <= '0;
      count_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_LEN: ref_len_r <= cfg_data[P-1:0];
        REG_WIN_LEN: win_len_r <= cfg_data[P-1:0];
        REG_STRIDE:  stride_r  <= cfg_data[P-1:0];
        REG_COUNT:   count_r   <= cfg_data[P-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // checks and window bounds
  cwr_front #(
    .POSITION_BITS(P)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .occ_start  (in_occurrence_start[P-1:0]),
    .occ_span   (in_occurrence_span[P-1:0]),
    .ref_len    (ref_len_r),
    .win_len    (win_len_r),
    .stride     (stride_r),
    .count      (count_r),
    .ctrl_o     (ctrl_c[0]),
    .min_start_o(dvd_lo_c[0]),
    .max_start_o(dvd_hi_c[0])
  );

  assign rem_lo_c[0] = '0;
  assign rem_hi_c[0] = '0;

  // divider chain, one quotient bit per cell for both bounds
  for (genvar i = 0; i < P; i++) begin : g_cell
    cwr_div_cell #(
      .POSITION_BITS(P)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stride  (stride_r),
      .ctrl_i  (ctrl_c[i]),
      .rem_lo_i(rem_lo_c[i]),
      .dvd_lo_i(dvd_lo_c[i]),
      .rem_hi_i(rem_hi_c[i]),
      .dvd_hi_i(dvd_hi_c[i]),
      .ctrl_o  (ctrl_c[i+1]),
      .rem_lo_o(rem_lo_c[i+1]),
      .dvd_lo_o(dvd_lo_c[i+1]),
      .rem_hi_o(rem_hi_c[i+1]),
      .dvd_hi_o(dvd_hi_c[i+1])
    );
  end

  // round the lower bound up, then catch a range with no window start in it
  always_comb begin
    lo       = dvd_lo_c[P] + P'(rem_lo_c[P] != '0);
    fin_ctrl = ctrl_c[P];
    if (ctrl_c[P].status == ST_OK && lo > dvd_hi_c[P]) begin
      fin_ctrl.status = ST_NONE;
    end
  end

  // output register; ids read as zero unless the range is valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_ctrl.valid;
    end
    out_status_r <= fin_ctrl.status;
    out_first_r  <= (fin_ctrl.status == ST_OK) ? FIELD_W'(lo) : '0;
    out_last_r   <= (fin_ctrl.status == ST_OK) ? FIELD_W'(dvd_hi_c[P]) : '0;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_first_window = out_first_r;
  assign out_last_window  = out_last_r;

endmodule
